@@ rtl/nbm_pkg.sv @@
package nbm_pkg;

    typedef logic [2:0] t_func;
    typedef logic [1:0] t_kind;

    localparam t_func FUNC_LOAD   = 3'd0;
    localparam t_func FUNC_FEED   = 3'd1;
    localparam t_func FUNC_TARGET = 3'd2;
    localparam t_func FUNC_DOWN   = 3'd3;
    localparam t_func FUNC_UPDATE = 3'd4;

    localparam t_kind KIND_OUTPUT = 2'd0;
    localparam t_kind KIND_GRAD   = 2'd1;
    localparam t_kind KIND_WEIGHT = 2'd2;

    // Q7.12 one
    localparam logic signed [19:0] Q12_ONE = 20'sd4096;

    // Clamp a wide signed value to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/neuron_backprop_momentum.sv @@
// Channel   | Dir | Fields
// s_axis    | in  | tuser=func, tdata={link_weight,value,index} low first, tlast=last_in
// m_axis    | out | tuser=kind, tdata={out_value,out_index} low first, tlast=last_out
// apb       | in  | reg 0 learn_rate at 0x0, reg 1 momentum at 0x4
//
// Load weight writes the weight store. Feed/downstream term: multiply, accumulate;
// closing adds the table lookup (feed) or the derivative and gradient steps
// (downstream) plus the result hand-off. Target: derivative and gradient steps
// plus hand-off. Update: LANES weights, each handed off; one shared multiplier.
// Reset (synchronous, active low) clears control state, the accumulator and
// the valid bits of the change and input stores. A stalled output holds the
// sequencer in its hand-off step; input is taken only while the sequencer idles.
module neuron_backprop_momentum #(
    parameter int NUM_INPUTS   = 16,
    parameter int TANH_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [39:0]        i_s_axis_tdata,   // index[3:0], value[19:4], link_weight[35:20]
    input  nbm_pkg::t_func     i_s_axis_tuser,   // func[2:0]
    input  logic               i_s_axis_tlast,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [23:0]        o_m_axis_tdata,   // out_index[3:0], out_value[19:4]
    output nbm_pkg::t_kind     o_m_axis_tuser,   // kind[1:0]
    output logic               o_m_axis_tlast,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import nbm_pkg::*;

    localparam int LANES = (NUM_INPUTS < 16) ? NUM_INPUTS : 16;
    localparam int LW    = $clog2(LANES);
    localparam int TIW   = $clog2(TANH_ENTRIES);

    localparam longint Q30 = 64'sd1 <<< 30;

    typedef logic signed [15:0] t_tab [TANH_ENTRIES];

    // Unsigned shift-and-subtract quotient for table building
    function automatic longint unsigned udiv(input longint unsigned n,
                                             input longint unsigned d);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], n[b]};
            if (rem >= d) begin
                rem    = rem - d;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Build the tanh table at elaboration
    function automatic t_tab build_tab();
        t_tab tab;
        longint unsigned x;
        longint unsigned w;
        longint unsigned term;
        longint sum;
        longint e;
        longint num;
        longint den;
        for (int i = 0; i < TANH_ENTRIES; i++) begin
            x    = udiv(64'(i) * 64'd32768, 64'(TANH_ENTRIES));
            w    = x << 15;
            sum  = Q30;
            term = Q30;
            for (int k = 1; k <= 24; k++) begin
                term = udiv((term * w) >> 30, 64'(k));
                if ((k & 1) == 1) sum = sum - longint'(term);
                else              sum = sum + longint'(term);
            end
            e = sum;
            for (int s = 0; s < 4; s++) begin
                e = (e * e + (Q30 >>> 1)) >>> 30;
            end
            num    = Q30 - e;
            den    = Q30 + e;
            tab[i] = 16'((longint'(udiv($unsigned(num <<< 13), $unsigned(den))) + 1) >>> 1);
        end
        return tab;
    endfunction

    localparam t_tab TANH_TAB = build_tab();

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_FMUL  = 5'd1;
    localparam logic [4:0] S_FADD  = 5'd2;
    localparam logic [4:0] S_CLOSE = 5'd3;
    localparam logic [4:0] S_TAB   = 5'd4;
    localparam logic [4:0] S_D1    = 5'd5;
    localparam logic [4:0] S_D2    = 5'd6;
    localparam logic [4:0] S_G2    = 5'd7;
    localparam logic [4:0] S_G3    = 5'd8;
    localparam logic [4:0] S_H1    = 5'd9;
    localparam logic [4:0] S_H2    = 5'd10;
    localparam logic [4:0] S_H3    = 5'd11;
    localparam logic [4:0] S_H4    = 5'd12;
    localparam logic [4:0] S_U0    = 5'd13;
    localparam logic [4:0] S_U1    = 5'd14;
    localparam logic [4:0] S_U2    = 5'd15;
    localparam logic [4:0] S_U3    = 5'd16;
    localparam logic [4:0] S_U4    = 5'd17;
    localparam logic [4:0] S_U5    = 5'd18;
    localparam logic [4:0] S_EMIT  = 5'd19;

    logic [4:0]               r_state;
    logic [4:0]               r_ret;
    t_func                    r_func;
    logic                     r_last;
    logic signed [15:0]       r_value;
    logic signed [15:0]       r_link;
    logic [LW-1:0]            r_ptr;
    logic signed [39:0]       r_mac;
    logic signed [15:0]       r_act;
    logic signed [15:0]       r_grad;
    logic signed [19:0]       r_deriv;
    logic signed [53:0]       r_prod;
    logic signed [59:0]       r_acc;
    logic [TIW-1:0]           r_tidx;
    logic                     r_tneg;
    logic [15:0]              r_eta;
    logic [15:0]              r_mom;

    logic signed [15:0]       w_mem   [LANES];
    logic signed [15:0]       wch_mem [LANES];
    logic signed [15:0]       lin_mem [LANES];
    logic [LANES-1:0]         r_wch_v;
    logic [LANES-1:0]         r_lin_v;
    logic signed [15:0]       r_wrd;
    logic signed [15:0]       r_wch_rd;
    logic signed [15:0]       r_lin_rd;

    t_kind                    r_res_kind;
    logic [3:0]               r_res_idx;
    logic signed [15:0]       r_res_val;
    logic                     r_res_last;

    logic                     r_ov;
    t_kind                    r_okind;
    logic [3:0]               r_oidx;
    logic [15:0]              r_oval;
    logic                     r_olast;

    // Input fields
    logic [3:0]               in_idx;
    logic signed [15:0]       in_value;
    logic signed [15:0]       in_link;
    logic                     in_ok;
    logic                     in_acc;
    logic [LW-1:0]            rd_addr;

    assign in_idx   = i_s_axis_tdata[3:0];
    assign in_value = $signed(i_s_axis_tdata[19:4]);
    assign in_link  = $signed(i_s_axis_tdata[35:20]);
    assign in_ok    = {1'b0, in_idx} < 5'(LANES);
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE);

    // Configuration port
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {16'd0, r_mom} : {16'd0, r_eta};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta <= 16'd9830;
            r_mom <= 16'd32768;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) r_mom <= pwdata[15:0];
            else          r_eta <= pwdata[15:0];
        end
    end

    // Shared multiplier operands
    logic signed [32:0] mul_a;
    logic signed [20:0] mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_FMUL: begin
                mul_a = 33'(r_value);
                mul_b = (r_func == FUNC_FEED) ? 21'(r_wrd) : 21'(r_link);
            end
            S_D1: begin
                mul_a = 33'(r_act);
                mul_b = 21'(r_act);
            end
            S_G2: begin
                mul_a = 33'(r_value) - 33'(r_act);
                mul_b = 21'(r_deriv);
            end
            S_H1: begin
                mul_a = 33'($signed(r_mac[39:20]));
                mul_b = 21'(r_deriv);
            end
            S_H2: begin
                mul_a = 33'($signed({1'b0, r_mac[19:0]}));
                mul_b = 21'(r_deriv);
            end
            S_U1: begin
                mul_a = 33'(r_lin_rd);
                mul_b = 21'(r_grad);
            end
            S_U2: begin
                mul_a = $signed(r_prod[32:0]);
                mul_b = 21'($signed({1'b0, r_eta}));
            end
            S_U3: begin
                mul_a = 33'(r_wch_rd);
                mul_b = 21'($signed({1'b0, r_mom}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Accumulator add with saturation at 40 bits
    logic signed [40:0] mac_sum;
    logic signed [39:0] mac_sat;

    assign mac_sum = 41'(r_mac) + 41'($signed(r_prod[31:0]));
    always_comb begin
        if (mac_sum[40] != mac_sum[39]) begin
            mac_sat = mac_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        end else begin
            mac_sat = mac_sum[39:0];
        end
    end

    // Table index from the rounded sum
    logic signed [40:0] close_r;
    logic signed [15:0] close_s;
    logic [16:0]        tab_abs;
    logic [30:0]        tab_prod;
    logic [15:0]        tab_sh;
    logic [TIW-1:0]     tab_idx;

    assign close_r  = (41'(r_mac) + 41'sd2048) >>> 12;
    assign close_s  = sat16(64'(close_r));
    assign tab_abs  = close_s[15] ? 17'(-$signed({close_s[15], close_s}))
                                  : {1'b0, close_s};
    assign tab_prod = {14'd0, tab_abs} * 31'(TANH_ENTRIES);
    assign tab_sh   = tab_prod[30:15];
    assign tab_idx  = (tab_sh >= 16'(TANH_ENTRIES)) ? TIW'(TANH_ENTRIES - 1)
                                                    : tab_sh[TIW-1:0];

    // Rounded products
    logic signed [53:0] sq_r;
    logic signed [15:0] grad_out;
    logic signed [15:0] grad_hid;
    logic signed [15:0] dw;
    logic signed [15:0] nw;

    assign sq_r     = (r_prod + 54'sd2048) >>> 12;
    assign grad_out = sat16(64'((r_prod + 54'sd2048) >>> 12));
    assign grad_hid = sat16(64'((r_acc + (60'sd1 <<< 23)) >>> 24));
    assign dw       = sat16(64'((r_acc + (60'sd1 <<< 27)) >>> 28));
    assign nw       = sat16(64'(17'(r_wrd) + 17'(dw)));

    assign rd_addr = (r_state == S_IDLE) ? (in_ok ? in_idx[LW-1:0] : '0) : r_ptr;

    // Stores: weights, changes and latched inputs, registered read
    always_ff @(posedge i_clk) begin
        r_wrd    <= w_mem[rd_addr];
        r_wch_rd <= r_wch_v[rd_addr] ? wch_mem[rd_addr] : 16'sd0;
        r_lin_rd <= r_lin_v[rd_addr] ? lin_mem[rd_addr] : 16'sd0;
        if (in_acc && in_ok && i_s_axis_tuser == FUNC_LOAD) begin
            w_mem[in_idx[LW-1:0]] <= in_value;
        end
        if (in_acc && in_ok && i_s_axis_tuser == FUNC_FEED) begin
            lin_mem[in_idx[LW-1:0]] <= in_value;
        end
        if (r_state == S_U5) begin
            w_mem[r_ptr]   <= nw;
            wch_mem[r_ptr] <= dw;
        end
    end

    // Multiplier and wide accumulator
    always_ff @(posedge i_clk) begin
        r_prod <= 54'(mul_a * mul_b);
        case (r_state)
            S_H2:    r_acc <= 60'(r_prod) <<< 20;
            S_H3:    r_acc <= r_acc + 60'(r_prod);
            S_U3:    r_acc <= 60'(r_prod);
            S_U4:    r_acc <= r_acc + (60'(r_prod) <<< 12);
            default: r_acc <= r_acc;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_func     <= FUNC_LOAD;
            r_last     <= 1'b0;
            r_ptr      <= '0;
            r_mac      <= '0;
            r_act      <= '0;
            r_grad     <= '0;
            r_deriv    <= '0;
            r_tidx     <= '0;
            r_tneg     <= 1'b0;
            r_wch_v    <= '0;
            r_lin_v    <= '0;
            r_res_kind <= KIND_OUTPUT;
            r_res_idx  <= '0;
            r_res_val  <= '0;
            r_res_last <= 1'b0;
            r_ov       <= 1'b0;
            r_okind    <= KIND_OUTPUT;
            r_oidx     <= '0;
            r_oval     <= '0;
            r_olast    <= 1'b0;
        end else begin
            // Drop a taken output item; the hand-off step reloads it itself
            if (r_ov && i_m_axis_tready && r_state != S_EMIT) r_ov <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_func  <= i_s_axis_tuser;
                        r_last  <= i_s_axis_tlast;
                        r_value <= in_value;
                        r_link  <= in_link;
                        case (i_s_axis_tuser)
                            FUNC_FEED: begin
                                if (in_ok) begin
                                    r_lin_v[in_idx[LW-1:0]] <= 1'b1;
                                    r_state <= S_FMUL;
                                end else if (i_s_axis_tlast) begin
                                    r_state <= S_CLOSE;
                                end
                            end
                            FUNC_TARGET: r_state <= S_D1;
                            FUNC_DOWN:   r_state <= S_FMUL;
                            FUNC_UPDATE: begin
                                r_ptr   <= '0;
                                r_state <= S_U0;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_FMUL: r_state <= S_FADD;
                S_FADD: begin
                    r_mac <= mac_sat;
                    if (!r_last)                 r_state <= S_IDLE;
                    else if (r_func == FUNC_FEED) r_state <= S_CLOSE;
                    else                          r_state <= S_D1;
                end
                S_CLOSE: begin
                    r_tidx  <= tab_idx;
                    r_tneg  <= close_s[15];
                    r_mac   <= '0;
                    r_state <= S_TAB;
                end
                S_TAB: begin
                    r_act      <= r_tneg ? -TANH_TAB[r_tidx] : TANH_TAB[r_tidx];
                    r_res_val  <= r_tneg ? -TANH_TAB[r_tidx] : TANH_TAB[r_tidx];
                    r_res_kind <= KIND_OUTPUT;
                    r_res_idx  <= '0;
                    r_res_last <= 1'b1;
                    r_ret      <= S_IDLE;
                    r_state    <= S_EMIT;
                end
                S_D1: r_state <= S_D2;
                S_D2: begin
                    r_deriv <= Q12_ONE - 20'(sq_r);
                    r_state <= (r_func == FUNC_TARGET) ? S_G2 : S_H1;
                end
                S_G2: r_state <= S_G3;
                S_G3: begin
                    r_grad     <= grad_out;
                    r_res_val  <= grad_out;
                    r_res_kind <= KIND_GRAD;
                    r_res_idx  <= '0;
                    r_res_last <= 1'b1;
                    r_ret      <= S_IDLE;
                    r_state    <= S_EMIT;
                end
                S_H1: r_state <= S_H2;
                S_H2: r_state <= S_H3;
                S_H3: r_state <= S_H4;
                S_H4: begin
                    r_grad     <= grad_hid;
                    r_mac      <= '0;
                    r_res_val  <= grad_hid;
                    r_res_kind <= KIND_GRAD;
                    r_res_idx  <= '0;
                    r_res_last <= 1'b1;
                    r_ret      <= S_IDLE;
                    r_state    <= S_EMIT;
                end
                S_U0: r_state <= S_U1;
                S_U1: r_state <= S_U2;
                S_U2: r_state <= S_U3;
                S_U3: r_state <= S_U4;
                S_U4: r_state <= S_U5;
                S_U5: begin
                    r_wch_v[r_ptr] <= 1'b1;
                    r_res_val      <= nw;
                    r_res_kind     <= KIND_WEIGHT;
                    r_res_idx      <= 4'(r_ptr);
                    r_res_last     <= (r_ptr == LW'(LANES - 1));
                    if (r_ptr == LW'(LANES - 1)) begin
                        r_ret <= S_IDLE;
                    end else begin
                        r_ret <= S_U0;
                        r_ptr <= r_ptr + 1'b1;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // Hand the result to the output register once it is free
                    if (!r_ov || i_m_axis_tready) begin
                        r_ov    <= 1'b1;
                        r_okind <= r_res_kind;
                        r_oidx  <= r_res_idx;
                        r_oval  <= r_res_val;
                        r_olast <= r_res_last;
                        r_state <= r_ret;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tuser  = r_okind;
    assign o_m_axis_tdata  = {4'd0, r_oval, r_oidx};
    assign o_m_axis_tlast  = r_olast;

    // Checks
    a_mac_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAB) |-> (r_mac == 40'sd0))
        else $error("accumulator not cleared after close");

    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != KIND_WEIGHT) |-> (o_m_axis_tdata[3:0] == 4'd0))
        else $error("non-weight item carries an index");

    a_last_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == KIND_WEIGHT && o_m_axis_tlast)
        |-> (o_m_axis_tdata[3:0] == 4'(LANES - 1)))
        else $error("last weight item at wrong index");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_ptr} <= (LW + 1)'(LANES - 1)))
        else $error("update pointer out of range");

endmodule
